// ----- rtl/core/bbr_pkg.sv -----
`timescale 1ns / 1ps
package bbr_pkg;

	localparam int MQ_DEPTH = 4;
	localparam int OQ_DEPTH = 4;
	localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_W = 18;
	localparam int COL_SUM_W = 10;
	localparam int SUM_W = 12;
	localparam int X_W = 13;
	localparam int PROD_W = X_W + RECIP_W;

	typedef logic [2:0][7:0] pix_t;

	typedef struct packed {
		logic [2:0] row_ok;
		logic [2:0] col_ok;
		logic [2:0] fwd_m;
		logic [2:0] fwd_r;
		logic [1:0] bank;
		logic [3:0] cnt;
		logic last;
		pix_t pix;
	} desc_t;

	typedef struct packed {
		desc_t desc;
		pix_t [2:0] col_m;
		pix_t [2:0] col_r;
	} mq_entry_t;

	typedef struct packed {
		pix_t rgb;
		logic last;
	} out_t;

	function automatic logic [3:0] blur_count(input logic [2:0] row_ok, input logic [2:0] col_ok);
		logic [1:0] nr;
		logic [1:0] nc;
		logic [3:0] p;
		nr = 2'(row_ok[0]) + 2'(row_ok[1]) + 2'(row_ok[2]);
		nc = 2'(col_ok[0]) + 2'(col_ok[1]) + 2'(col_ok[2]);
		p = {2'b00, nr} * {2'b00, nc};
		if (p == 4'd0) begin
			p = 4'd1;
		end
		return p;
	endfunction

	// Rounded-up reciprocal of twice the count, scaled by two to the eighteenth.
	function automatic logic [RECIP_W-1:0] blur_recip(input logic [3:0] cnt);
		logic [RECIP_W-1:0] r;
		unique case (cnt)
			4'd1: r = 18'd131072;
			4'd2: r = 18'd65536;
			4'd3: r = 18'd43691;
			4'd4: r = 18'd32768;
			4'd5: r = 18'd26215;
			4'd6: r = 18'd21846;
			4'd7: r = 18'd18725;
			4'd8: r = 18'd16384;
			4'd9: r = 18'd14564;
			default: r = 18'd131072;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/box_blur_3x3_rgb.sv -----
// A released result passes the front register, the middle queue, back stages s1 and s2, and the output queue.
// Throughput: one request per cycle unless full, set by two reads of each of the three row stores per cycle.
// A result follows its pixel by one row plus one pixel; drain requests release the last
// width+1, or width for a single-row frame.
// Reset is asynchronous and active low; it clears counters and queues, and sets both
// frame registers to 1. Row stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module box_blur_3x3_rgb #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        frame_end
);
	import bbr_pkg::*;

	logic [10:0] width_q, height_q;
	logic mq_push, mq_pop, mq_empty, oq_push, oq_empty;
	logic [MQ_CNT_W-1:0] mq_count;
	logic [OQ_CNT_W-1:0] oq_count;
	mq_entry_t mq_wdata, mq_rdata;
	out_t oq_wdata, oq_rdata;

	assign pready = 1'b1;
	assign prdata = {21'd0, paddr[2] ? height_q : width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1;
			height_q <= 11'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				height_q <= pwdata[10:0];
			end else begin
				width_q <= pwdata[10:0];
			end
		end
	end

	bbr_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.frame_width(width_q),
		.frame_height(height_q),
		.push(push),
		.full(full),
		.kind(kind),
		.in_red(in_red),
		.in_green(in_green),
		.in_blue(in_blue),
		.mq_count(mq_count),
		.mq_push(mq_push),
		.mq_data(mq_wdata)
	);

	bbr_fifo #(
		.WIDTH($bits(mq_entry_t)),
		.DEPTH(MQ_DEPTH)
	) u_mq (
		.clk(clk),
		.arst_n(arst_n),
		.push(mq_push),
		.wdata(mq_wdata),
		.pop(mq_pop),
		.rdata(mq_rdata),
		.count(mq_count),
		.empty(mq_empty)
	);

	bbr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mq_empty(mq_empty),
		.mq_data(mq_rdata),
		.mq_pop(mq_pop),
		.oq_count(oq_count),
		.oq_push(oq_push),
		.oq_data(oq_wdata)
	);

	bbr_fifo #(
		.WIDTH($bits(out_t)),
		.DEPTH(OQ_DEPTH)
	) u_oq (
		.clk(clk),
		.arst_n(arst_n),
		.push(oq_push),
		.wdata(oq_wdata),
		.pop(pop),
		.rdata(oq_rdata),
		.count(oq_count),
		.empty(oq_empty)
	);

	assign empty = oq_empty;
	assign out_red = oq_rdata.rgb[2];
	assign out_green = oq_rdata.rgb[1];
	assign out_blue = oq_rdata.rgb[0];
	assign frame_end = oq_rdata.last;
endmodule

// ----- rtl/core/bbr_ram.sv -----
`timescale 1ns / 1ps
module bbr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

// ----- rtl/core/bbr_fifo.sv -----
`timescale 1ns / 1ps
module bbr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       empty
);
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;
	logic do_pop;

	assign empty = (count_q == '0);
	assign count = count_q;
	assign rdata = slot_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ----- rtl/core/bbr_front.sv -----
`timescale 1ns / 1ps
module bbr_front #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [10:0]                       frame_width,
	input  logic [10:0]                       frame_height,
	input  logic                              push,
	output logic                              full,
	input  logic                              kind,
	input  logic [7:0]                        in_red,
	input  logic [7:0]                        in_green,
	input  logic [7:0]                        in_blue,
	input  logic [bbr_pkg::MQ_CNT_W-1:0]      mq_count,
	output logic                              mq_push,
	output bbr_pkg::mq_entry_t                mq_data
);
	import bbr_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS + 1);

	logic [CW-1:0] eff_w;
	logic [RW-1:0] eff_h;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [1:0] in_bank_q, out_bank_q;
	logic recv_q;

	logic [CW:0] w_ext, col_inc, in_col_inc;
	logic [RW:0] h_ext, row_inc, in_row_inc;
	logic accept, pix_take, emit_ok, emit, col_end, row_end, last;
	logic in_col_end, in_row_end;
	logic [2:0] row_match;
	logic [2:0] row_ok, col_ok;
	pix_t pix;
	desc_t desc;
	desc_t desc_s1;
	logic v_s1;
	pix_t [2:0] rd_m, rd_r;

	always_comb begin
		if (frame_width == 11'd0) begin
			eff_w = CW'(1);
		end else if (32'(frame_width) > MAX_COLUMNS) begin
			eff_w = CW'(MAX_COLUMNS);
		end else begin
			eff_w = CW'(frame_width);
		end
		if (frame_height == 11'd0) begin
			eff_h = RW'(1);
		end else if (32'(frame_height) > MAX_ROWS) begin
			eff_h = RW'(MAX_ROWS);
		end else begin
			eff_h = RW'(frame_height);
		end
	end

	assign w_ext = {1'b0, eff_w};
	assign h_ext = {1'b0, eff_h};
	assign col_inc = {1'b0, out_col_q} + 1'b1;
	assign row_inc = {1'b0, out_row_q} + 1'b1;
	assign in_col_inc = {1'b0, in_col_q} + 1'b1;
	assign in_row_inc = {1'b0, in_row_q} + 1'b1;
	assign col_end = col_inc >= w_ext;
	assign row_end = row_inc >= h_ext;
	assign in_col_end = in_col_inc >= w_ext;
	assign in_row_end = in_row_inc >= h_ext;
	assign last = col_end && row_end;

	assign full = (32'(mq_count) + 32'(v_s1)) >= MQ_DEPTH;
	assign accept = push && !full;
	assign pix_take = accept && !kind && !recv_q;
	assign emit_ok = kind ? recv_q :
		(!recv_q && ((32'(in_row_q) >= 32'd2) || (32'(in_row_q) == 32'd1 && in_col_q != '0)));
	assign emit = accept && emit_ok;
	assign pix = {in_red, in_green, in_blue};

	always_comb begin
		row_ok[0] = (out_row_q != '0) && ({1'b0, out_row_q} <= h_ext);
		row_ok[1] = {1'b0, out_row_q} < h_ext;
		row_ok[2] = row_inc < h_ext;
		col_ok[0] = (out_col_q != '0) && ({1'b0, out_col_q} <= w_ext);
		col_ok[1] = {1'b0, out_col_q} < w_ext;
		col_ok[2] = col_inc < w_ext;
		row_match[0] = (out_row_q != '0) && (in_row_inc == {1'b0, out_row_q});
		row_match[1] = in_row_q == out_row_q;
		row_match[2] = {1'b0, in_row_q} == row_inc;
		desc.row_ok = row_ok;
		desc.col_ok = col_ok;
		desc.fwd_m = row_match & {3{!kind && (in_col_q == out_col_q)}};
		desc.fwd_r = row_match & {3{!kind && ({1'b0, in_col_q} == col_inc)}};
		desc.bank = out_bank_q;
		desc.cnt = blur_count(row_ok, col_ok);
		desc.last = last;
		desc.pix = pix;
	end

	for (genvar k = 0; k < 3; k++) begin : g_bank
		bbr_ram #(
			.WIDTH($bits(pix_t)),
			.DEPTH(MAX_COLUMNS)
		) u_ram (
			.clk(clk),
			.we(pix_take && (in_bank_q == 2'(k))),
			.waddr(in_col_q[AW-1:0]),
			.wdata(pix),
			.raddr_a(out_col_q[AW-1:0]),
			.rdata_a(rd_m[k]),
			.raddr_b(col_inc[AW-1:0]),
			.rdata_b(rd_r[k])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			in_bank_q <= 2'd0;
			out_bank_q <= 2'd0;
			recv_q <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= emit;
			if (emit) begin
				if (last) begin
					in_col_q <= '0;
					in_row_q <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
					in_bank_q <= 2'd0;
					out_bank_q <= 2'd0;
					recv_q <= 1'b0;
				end else if (col_end) begin
					out_col_q <= '0;
					out_row_q <= row_inc[RW-1:0];
					out_bank_q <= (out_bank_q == 2'd2) ? 2'd0 : out_bank_q + 2'd1;
				end else begin
					out_col_q <= col_inc[CW-1:0];
				end
			end
			if (pix_take) begin
				if (in_col_end) begin
					in_col_q <= '0;
					if (in_row_end) begin
						in_row_q <= '0;
						in_bank_q <= 2'd0;
						recv_q <= 1'b1;
					end else begin
						in_row_q <= in_row_inc[RW-1:0];
						in_bank_q <= (in_bank_q == 2'd2) ? 2'd0 : in_bank_q + 2'd1;
					end
				end else begin
					in_col_q <= in_col_inc[CW-1:0];
				end
			end
		end
	end

	assign mq_push = v_s1;
	assign mq_data.desc = desc_s1;
	assign mq_data.col_m = rd_m;
	assign mq_data.col_r = rd_r;
endmodule

// ----- rtl/core/bbr_back.sv -----
`timescale 1ns / 1ps
module bbr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         mq_empty,
	input  bbr_pkg::mq_entry_t           mq_data,
	output logic                         mq_pop,
	input  logic [bbr_pkg::OQ_CNT_W-1:0] oq_count,
	output logic                         oq_push,
	output bbr_pkg::out_t                oq_data
);
	import bbr_pkg::*;

	logic [2:0][1:0] bank_of;
	pix_t [2:0] pf, pm, pr, pl;
	logic [2:0][COL_SUM_W-1:0] sum_m, sum_r, sum_l;
	logic [2:0][X_W-1:0] x_c;
	pix_t [2:0] prev_q;
	logic [2:0][X_W-1:0] x_s1;
	logic [RECIP_W-1:0] recip_s1;
	logic last_s1, v_s1;
	logic [2:0][PROD_W-1:0] prod_s2;
	logic last_s2, v_s2;
	desc_t d;

	assign d = mq_data.desc;
	assign mq_pop = !mq_empty && ((32'(oq_count) + 32'(v_s1) + 32'(v_s2)) < OQ_DEPTH);

	always_comb begin
		bank_of[0] = (d.bank == 2'd0) ? 2'd2 : d.bank - 2'd1;
		bank_of[1] = d.bank;
		bank_of[2] = (d.bank == 2'd2) ? 2'd0 : d.bank + 2'd1;
		for (int i = 0; i < 3; i++) begin
			pf[i] = d.fwd_m[i] ? d.pix : mq_data.col_m[bank_of[i]];
			pm[i] = pf[i];
			pr[i] = d.fwd_r[i] ? d.pix : mq_data.col_r[bank_of[i]];
			pl[i] = prev_q[i];
			if (!(d.row_ok[i] && d.col_ok[1])) begin
				pm[i] = '0;
			end
			if (!(d.row_ok[i] && d.col_ok[2])) begin
				pr[i] = '0;
			end
			if (!(d.row_ok[i] && d.col_ok[0])) begin
				pl[i] = '0;
			end
		end
		for (int c = 0; c < 3; c++) begin
			sum_m[c] = COL_SUM_W'(pm[0][c]) + COL_SUM_W'(pm[1][c]) + COL_SUM_W'(pm[2][c]);
			sum_r[c] = COL_SUM_W'(pr[0][c]) + COL_SUM_W'(pr[1][c]) + COL_SUM_W'(pr[2][c]);
			sum_l[c] = COL_SUM_W'(pl[0][c]) + COL_SUM_W'(pl[1][c]) + COL_SUM_W'(pl[2][c]);
			x_c[c] = {SUM_W'(sum_l[c]) + SUM_W'(sum_m[c]) + SUM_W'(sum_r[c]), 1'b0}
				+ X_W'(d.cnt);
		end
	end

	always_ff @(posedge clk) begin
		if (mq_pop) begin
			prev_q <= pf;
			x_s1 <= x_c;
			recip_s1 <= blur_recip(d.cnt);
			last_s1 <= d.last;
		end
		if (v_s1) begin
			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= {{RECIP_W{1'b0}}, x_s1[c]} * {{X_W{1'b0}}, recip_s1};
			end
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= mq_pop;
			v_s2 <= v_s1;
		end
	end

	assign oq_push = v_s2;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			oq_data.rgb[c] = prod_s2[c][RECIP_SHIFT +: 8];
		end
		oq_data.last = last_s2;
	end
endmodule
